/* hw/rtl/utf8_word_accent_folder_unit_defines.svh */
// assertion macros shared by the accent folder rtl
// no dependencies; include with the bare file name
`ifndef UTF8_WORD_ACCENT_FOLDER_UNIT_DEFINES_SVH
`define UTF8_WORD_ACCENT_FOLDER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define UWAF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define UWAF_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define UWAF_ASSERT(name, prop, msg)
`define UWAF_ASSERT_NEVER(name, cond, msg)
`endif
`endif

/* hw/rtl/uwaf_pkg.sv */
// types, constants and the latin fold table for the accent folder
// no dependencies
`default_nettype none
package uwaf_pkg;

  localparam int MAX_SEQ_BYTES = 6;
  localparam int HCNT_W        = $clog2(MAX_SEQ_BYTES + 1);
  localparam int REC_BYTES     = 7;
  localparam int REC_CNT_W     = 3;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = 1;
  localparam int QCNT_W        = 2;

  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_TERM   = 8'h00;
  localparam logic [8:0] FOLD_BASE = 9'h0C0;
  localparam logic [8:0] FOLD_LAST = 9'h17F;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last_out;
  } out_item_t;

  typedef struct packed {
    logic                          two;
    logic [7:0]                    first;
    logic [7:0]                    second;
  } fold_t;

  typedef struct packed {
    logic [REC_BYTES-1:0][7:0] bytes;
    logic [REC_CNT_W-1:0]      cnt;
    logic                      term;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic fold_t one(input logic [7:0] c);
    fold_t f;
    f.two    = 1'b0;
    f.first  = c;
    f.second = c;
    return f;
  endfunction

  function automatic fold_t pair(input logic [7:0] a, input logic [7:0] b);
    fold_t f;
    f.two    = 1'b1;
    f.first  = a;
    f.second = b;
    return f;
  endfunction

  // idx is the code point minus U+00C0
  function automatic fold_t fold_lookup(input logic [7:0] idx);
    logic [3:0] q;
    fold_t      f;
    q = idx[3:0];
    if (idx < 8'd64) begin
      if (!idx[4]) begin
        if (q < 4'd6)       f = one("a");
        else if (q == 4'd6) f = pair("a", "e");
        else if (q == 4'd7) f = one("c");
        else if (q < 4'd12) f = one("e");
        else                f = one("i");
      end else begin
        if (q == 4'd0)       f = pair("t", "h");
        else if (q == 4'd1)  f = one("n");
        else if (q < 4'd7)   f = one("o");
        else if (q == 4'd7)  f = idx[5] ? one("/") : one("*");
        else if (q == 4'd8)  f = one("o");
        else if (q < 4'd13)  f = one("u");
        else if (q == 4'd13) f = one("y");
        else if (q == 4'd14) f = pair("t", "h");
        else                 f = idx[5] ? one("y") : pair("s", "s");
      end
    end else begin
      if (idx < 8'd70)       f = one("a");
      else if (idx < 8'd78)  f = one("c");
      else if (idx < 8'd82)  f = one("d");
      else if (idx < 8'd92)  f = one("e");
      else if (idx < 8'd100) f = one("g");
      else if (idx < 8'd104) f = one("h");
      else if (idx < 8'd114) f = one("i");
      else if (idx < 8'd116) f = pair("i", "j");
      else if (idx < 8'd118) f = one("j");
      else if (idx < 8'd121) f = one("k");
      else if (idx < 8'd131) f = one("l");
      else if (idx < 8'd138) f = one("n");
      else if (idx < 8'd140) f = pair("n", "g");
      else if (idx < 8'd146) f = one("o");
      else if (idx < 8'd148) f = pair("o", "e");
      else if (idx < 8'd154) f = one("r");
      else if (idx < 8'd162) f = one("s");
      else if (idx < 8'd168) f = one("t");
      else if (idx < 8'd180) f = one("u");
      else if (idx < 8'd182) f = one("w");
      else if (idx < 8'd185) f = one("y");
      else if (idx < 8'd191) f = one("z");
      else                   f = one("s");
    end
    return f;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/utf8_word_accent_folder_unit.sv */
// utf-8 word accent folder, top level
// Takes one byte of a UTF-8 word per transfer and returns the folded bytes
// followed by a zero terminator marked last. The front end accepts one byte
// every cycle while the queue is not full; each byte turns into a record of
// zero to seven output bytes that goes into a two-entry queue. The back end
// sends one byte per cycle through its output register while out_stall_i
// is low, so an item with k results holds the output until all k are sent;
// the input stalls once the queue is full behind a long record (a flushed
// sequence plus terminator). Results pass through the queue, then the output register.
// depends on uwaf_pkg, uwaf_front, uwaf_queue and uwaf_back
`default_nettype none
module utf8_word_accent_folder_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire uwaf_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output uwaf_pkg::out_item_t    out_data_o
);
  import uwaf_pkg::*;

  rec_t    push_rec, head_rec;
  logic    push, pop;
  q_stat_t q_stat;

  uwaf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  uwaf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (push_rec),
    .pop_i  (pop),
    .rec_o  (head_rec),
    .stat_o (q_stat)
  );

  uwaf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (head_rec),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

/* hw/rtl/uwaf_front.sv */
// front end: takes input bytes, decodes utf-8 sequences and builds at most one output record per item
// depends on uwaf_pkg and the assertion macro header
`default_nettype none
`include "utf8_word_accent_folder_unit_defines.svh"
module uwaf_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire uwaf_pkg::in_item_t in_data_i,
  input  wire uwaf_pkg::q_stat_t  q_stat_i,
  output logic                   push_o,
  output uwaf_pkg::rec_t         rec_o
);
  import uwaf_pkg::*;

  logic [MAX_SEQ_BYTES-1:0][7:0] held_q, held_d;
  logic [HCNT_W-1:0]             hcnt_q, hcnt_d;
  logic [HCNT_W-1:0]             need_q, need_d;
  logic [8:0]                    cp_q, cp_d;
  logic                          cphi_q, cphi_d;

  logic       accept;
  logic [7:0] b;
  logic       is_ascii, is_lead, fr_hold, fr_emit;
  logic [2:0] fr_more;
  logic [4:0] fr_pay;
  logic [7:0] fr_byte;
  logic [8:0] nx_cp;
  logic       nx_hi;
  logic       in_range;
  fold_t      fold;

  logic [MAX_SEQ_BYTES-1:0][7:0] s;
  logic [HCNT_W-1:0]             sc;
  logic [1:0]                    tc;
  logic [7:0]                    t0, t1;
  logic                          term;

  assign accept     = in_valid_i && !q_stat_i.full;
  assign in_stall_o = q_stat_i.full;
  assign b          = in_data_i.byte_in;
  assign is_ascii   = !b[7];

  // lead byte decode
  always_comb begin
    is_lead = 1'b1;
    fr_more = 3'd0;
    fr_pay  = 5'd0;
    priority if (b[7:5] == 3'b110) begin
      fr_more = 3'd1;
      fr_pay  = b[4:0];
    end else if (b[7:4] == 4'b1110) begin
      fr_more = 3'd2;
      fr_pay  = {1'b0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      fr_more = 3'd3;
      fr_pay  = {2'b0, b[2:0]};
    end else if (b[7:2] == 6'b111110) begin
      fr_more = 3'd4;
      fr_pay  = {3'b0, b[1:0]};
    end else if (b[7:1] == 7'b1111110) begin
      fr_more = 3'd5;
      fr_pay  = {4'b0, b[0]};
    end else begin
      is_lead = 1'b0;
    end
  end

  assign fr_hold = is_lead && ((4'(fr_more) + 4'd1) <= 4'(MAX_SEQ_BYTES));
  assign fr_emit = is_ascii ? (b != CH_APOS) : !fr_hold;
  assign fr_byte = (is_ascii && b >= "A" && b <= "Z") ? (b | 8'h20) : b;

  // code point once the current continuation byte is taken in
  assign nx_cp    = {cp_q[2:0], b[5:0]};
  assign nx_hi    = cphi_q || (cp_q[8:3] != '0);
  assign in_range = !nx_hi && nx_cp >= FOLD_BASE && nx_cp <= FOLD_LAST;
  assign fold     = fold_lookup(8'(nx_cp - FOLD_BASE));

  always_comb begin
    held_d = held_q;
    hcnt_d = hcnt_q;
    need_d = need_q;
    cp_d   = cp_q;
    cphi_d = cphi_q;
    s      = held_q;
    sc     = '0;
    tc     = 2'd0;
    t0     = fr_byte;
    t1     = fr_byte;
    term   = 1'b0;
    if (need_q != '0 && b[7:6] == 2'b10 && hcnt_q < HCNT_W'(MAX_SEQ_BYTES)) begin
      // continuation byte
      held_d[hcnt_q] = b;
      hcnt_d         = hcnt_q + 1'b1;
      cp_d           = nx_cp;
      cphi_d         = nx_hi;
      need_d         = need_q - 1'b1;
      if (need_d == '0) begin
        if (in_range) begin
          tc = fold.two ? 2'd2 : 2'd1;
          t0 = fold.first;
          t1 = fold.second;
        end else begin
          sc = hcnt_d;
          s  = held_d;
        end
        hcnt_d = '0;
        cp_d   = '0;
        cphi_d = 1'b0;
      end
    end else begin
      if (need_q != '0) begin
        // broken sequence
        sc     = hcnt_q;
        hcnt_d = '0;
        need_d = '0;
        cp_d   = '0;
        cphi_d = 1'b0;
      end
      if (fr_hold) begin
        held_d[0] = b;
        hcnt_d    = HCNT_W'(1);
        need_d    = HCNT_W'(fr_more);
        cp_d      = {4'b0, fr_pay};
        cphi_d    = 1'b0;
      end else if (fr_emit) begin
        tc = 2'd1;
      end
    end
    if (in_data_i.last_in) begin
      term = 1'b1;
      if (hcnt_d != '0) begin
        if (sc == '0) begin
          sc = hcnt_d;
          s  = held_d;
        end else begin
          tc = 2'd1;
          t0 = b;
        end
      end
      hcnt_d = '0;
      need_d = '0;
      cp_d   = '0;
      cphi_d = 1'b0;
    end
  end

  // pack held bytes, then folded or raw bytes, then the terminator
  always_comb begin
    for (int i = 0; i < REC_BYTES; i++) begin
      if ((4'(i) - {1'b0, sc}) == 4'd0 && tc != 2'd0) rec_o.bytes[i] = t0;
      else if ((4'(i) - {1'b0, sc}) == 4'd1 && tc == 2'd2) rec_o.bytes[i] = t1;
      else rec_o.bytes[i] = CH_TERM;
    end
    for (int i = 0; i < MAX_SEQ_BYTES; i++) begin
      if (HCNT_W'(i) < sc) rec_o.bytes[i] = s[i];
    end
    rec_o.cnt  = REC_CNT_W'({1'b0, sc} + {2'b0, tc} + {3'b0, term});
    rec_o.term = term;
  end

  assign push_o = accept && (sc != '0 || tc != 2'd0 || term);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q <= '0;
      need_q <= '0;
      cp_q   <= '0;
      cphi_q <= 1'b0;
    end else if (accept) begin
      hcnt_q <= hcnt_d;
      need_q <= need_d;
      cp_q   <= cp_d;
      cphi_q <= cphi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) held_q <= held_d;
  end

  `UWAF_ASSERT(a_hold_pairs, (need_q != '0) == (hcnt_q != '0), "held count and need disagree")
  `UWAF_ASSERT(a_seq_len, ({1'b0, hcnt_q} + {1'b0, need_q}) <= 4'(MAX_SEQ_BYTES), "sequence too long")
  `UWAF_ASSERT(a_last_clears, accept && in_data_i.last_in |=> hcnt_q == '0, "hold survives end of word")

endmodule
`default_nettype wire

/* hw/rtl/uwaf_queue.sv */
// two-entry record queue between the decode front and the output back end
// depends on uwaf_pkg
`default_nettype none
module uwaf_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire uwaf_pkg::rec_t rec_i,
  input  wire logic           pop_i,
  output uwaf_pkg::rec_t      rec_o,
  output uwaf_pkg::q_stat_t   stat_o
);
  import uwaf_pkg::*;

  rec_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign rec_o        = mem_q[rd_q];
  assign stat_o.full  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign stat_o.empty = cnt_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= rec_i;
  end

endmodule
`default_nettype wire

/* hw/rtl/uwaf_back.sv */
// back end: while not stalled, walks the head record one byte per cycle into
// the output register; depends on uwaf_pkg and the assertion macro header
`default_nettype none
`include "utf8_word_accent_folder_unit_defines.svh"
module uwaf_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire uwaf_pkg::rec_t    rec_i,
  input  wire uwaf_pkg::q_stat_t q_stat_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output uwaf_pkg::out_item_t    out_data_o
);
  import uwaf_pkg::*;

  logic [REC_CNT_W-1:0] pos_q, pos_d;
  logic                 valid_q;
  out_item_t            out_q;
  logic                 load, at_end;

  assign load   = !valid_q || !out_stall_i;
  assign at_end = pos_q == (rec_i.cnt - 1'b1);
  assign pop_o  = load && !q_stat_i.empty && at_end;
  assign pos_d  = at_end ? '0 : pos_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else if (load) begin
      valid_q <= !q_stat_i.empty;
      if (!q_stat_i.empty) pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !q_stat_i.empty) begin
      out_q.byte_out <= rec_i.bytes[pos_q];
      out_q.last_out <= rec_i.term && at_end;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

  `UWAF_ASSERT(a_pos_idle, q_stat_i.empty |-> pos_q == '0, "walk position left over")
  `UWAF_ASSERT(a_pos_bound, !q_stat_i.empty |-> pos_q < rec_i.cnt, "walk past record end")
  `UWAF_ASSERT_NEVER(a_term_zero, valid_q && out_q.last_out && out_q.byte_out != CH_TERM,
                     "terminator not zero")

endmodule
`default_nettype wire
